// File: rtl/core/lpf_pkg.sv
// Shared types and constants for the LED PWM fade controller.
// No dependencies; used by lpf_ctrl, lpf_dp and led_pwm_fade_controller.

package lpf_pkg;

    localparam int LED_IDX_W = 6;
    localparam int LEVEL_W   = 4;
    localparam int INTV_W    = 8;
    localparam int MASK_W    = 64;
    localparam int IN_DATA_W = 16;

    localparam logic [LEVEL_W-1:0] PWM_TOP_RST   = 4'd10;
    localparam logic [INTV_W-1:0]  FADE_INTV_RST = 8'd25;

    // register index, taken from paddr[2]
    localparam logic REG_PWM_TOP   = 1'b0;
    localparam logic REG_FADE_INTV = 1'b1;

    // word kind on tuser
    localparam logic FUNC_TICK = 1'b0;
    localparam logic FUNC_SET  = 1'b1;

    typedef struct packed {
        logic set_wr;
        logic tick_start;
        logic sweep_rd;
        logic mask_load;
    } t_dp_cmd;

    typedef struct packed {
        logic sweep_last;
    } t_dp_sts;

endpackage

// File: rtl/core/led_pwm_fade_controller.sv
// Top level of the LED PWM fade controller: APB register file, sequencer and datapath.
// Depends on lpf_pkg, lpf_ctrl and lpf_dp.
//
//  Channel   | Direction | Handshake              | Contents
//  ----------+-----------+------------------------+----------------------------------------
//  s_axis    | in        | tvalid / tready        | tick or set word: tuser = func,
//            |           |                        | tdata = led_index, level, immediate
//  m_axis    | out       | tvalid / tready        | tdata = led_on_mask, one word per tick
//  apb       | in        | psel, penable, pready  | pwm_top @ 0x0, fade_interval @ 0x4
//
// A tick word walks every channel entry through the level memories, one read per
// cycle, before the mask is registered on m_axis. Reset is synchronous and active low;
// it restores phase, countdown and registers, and marks every level entry as zero
// through its valid bit, so no clearing pass is needed. A stalled mask word holds in
// the output register while the next tick sweeps; only its final load waits on it.

module led_pwm_fade_controller #(
    parameter int NUM_LEDS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [5:0] led_index, [9:6] level, [10] immediate
    input  logic        i_s_axis_tuser,   // [0] func (0 tick, 1 set)

    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [63:0] o_m_axis_tdata,   // [63:0] led_on_mask

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [lpf_pkg::LEVEL_W-1:0] r_pwm_top;
    logic [lpf_pkg::INTV_W-1:0]  r_fade_intv;
    logic                        cfg_wr;
    logic                        reg_sel;

    lpf_pkg::t_dp_cmd dp_cmd;
    lpf_pkg::t_dp_sts dp_sts;

    // Register file: low address bits are don't-care, paddr[2] picks the register.
    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pwm_top   <= lpf_pkg::PWM_TOP_RST;
            r_fade_intv <= lpf_pkg::FADE_INTV_RST;
        end else if (cfg_wr) begin
            case (reg_sel)
                lpf_pkg::REG_PWM_TOP:   r_pwm_top   <= pwdata[lpf_pkg::LEVEL_W-1:0];
                lpf_pkg::REG_FADE_INTV: r_fade_intv <= pwdata[lpf_pkg::INTV_W-1:0];
                default: begin
                    r_pwm_top <= r_pwm_top;
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            lpf_pkg::REG_PWM_TOP:   prdata = 32'(r_pwm_top);
            lpf_pkg::REG_FADE_INTV: prdata = 32'(r_fade_intv);
            default:                prdata = '0;
        endcase
    end

    // Sequencer: accepts words only when idle, runs the channel sweep for ticks.
    lpf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_axis_tvalid),
        .i_s_func   (i_s_axis_tuser),
        .o_s_tready (o_s_axis_tready),
        .o_m_tvalid (o_m_axis_tvalid),
        .i_m_tready (i_m_axis_tready),
        .i_sts      (dp_sts),
        .o_cmd      (dp_cmd)
    );

    // Datapath: level memories, phase and countdown, mask assembly and output register.
    lpf_dp #(
        .NUM_LEDS (NUM_LEDS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (dp_cmd),
        .o_sts       (dp_sts),
        .i_led_index (i_s_axis_tdata[5:0]),
        .i_level     (i_s_axis_tdata[9:6]),
        .i_immediate (i_s_axis_tdata[10]),
        .i_pwm_top   (r_pwm_top),
        .i_fade_intv (r_fade_intv),
        .o_mask      (o_m_axis_tdata)
    );

endmodule

// File: rtl/core/lpf_ctrl.sv
// Sequencer for the LED PWM fade controller: input/output handshakes and sweep control.
// Depends on lpf_pkg; drives lpf_dp through t_dp_cmd.

module lpf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    input  logic             i_s_func,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    input  lpf_pkg::t_dp_sts i_sts,
    output lpf_pkg::t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FLUSH,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   in_acc;

    always_comb begin
        o_cmd      = '0;
        n_state    = r_state;
        o_s_tready = (r_state == ST_IDLE);
        in_acc     = i_s_tvalid && (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                o_cmd.set_wr     = in_acc && (i_s_func == lpf_pkg::FUNC_SET);
                o_cmd.tick_start = in_acc && (i_s_func == lpf_pkg::FUNC_TICK);
                if (o_cmd.tick_start) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                o_cmd.sweep_rd = 1'b1;
                if (i_sts.sweep_last) begin
                    n_state = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                // last channel's read data lands this cycle
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                o_cmd.mask_load = !r_out_valid || i_m_tready;
                if (o_cmd.mask_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_cmd.mask_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_m_tvalid = r_out_valid;

endmodule

// File: rtl/core/lpf_dp.sv
// Datapath for the LED PWM fade controller: level memories, phase, fade countdown, mask.
// Depends on lpf_pkg; commanded by lpf_ctrl.

module lpf_dp #(
    parameter int NUM_LEDS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  lpf_pkg::t_dp_cmd                i_cmd,
    output lpf_pkg::t_dp_sts                o_sts,
    input  logic [lpf_pkg::LED_IDX_W-1:0]   i_led_index,
    input  logic [lpf_pkg::LEVEL_W-1:0]     i_level,
    input  logic                            i_immediate,
    input  logic [lpf_pkg::LEVEL_W-1:0]     i_pwm_top,
    input  logic [lpf_pkg::INTV_W-1:0]      i_fade_intv,
    output logic [lpf_pkg::MASK_W-1:0]      o_mask
);

    localparam int AW = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int LW = lpf_pkg::LEVEL_W;

    logic [LW-1:0] tgt_mem [NUM_LEDS];
    logic [LW-1:0] cur_mem [NUM_LEDS];

    logic [NUM_LEDS-1:0]          r_tgt_vld;
    logic [NUM_LEDS-1:0]          r_cur_vld;
    logic [LW-1:0]                r_phase;
    logic [lpf_pkg::INTV_W-1:0]   r_cd;
    logic                         r_step;
    logic [AW-1:0]                r_addr;
    logic                         r_rd_pend;
    logic [AW-1:0]                r_rd_idx;
    logic [LW-1:0]                r_tgt_q;
    logic [LW-1:0]                r_cur_q;
    logic                         r_tgt_v;
    logic                         r_cur_v;
    logic [NUM_LEDS-1:0]          r_mask;
    logic [NUM_LEDS-1:0]          r_out_mask;

    logic [LW-1:0]                lvl_sat;
    logic                         idx_ok;
    logic [AW-1:0]                set_addr;
    logic [LW:0]                  phase_inc;
    logic [LW-1:0]                phase_next;
    logic [lpf_pkg::INTV_W-1:0]   cd_dec;
    logic [LW-1:0]                tgt_eff;
    logic [LW-1:0]                cur_eff;
    logic [LW-1:0]                cur_step;
    logic                         tgt_we;
    logic                         cur_we;
    logic [AW-1:0]                cur_wa;
    logic [LW-1:0]                cur_wd;

    always_comb begin
        lvl_sat    = (i_level > i_pwm_top) ? i_pwm_top : i_level;
        idx_ok     = {1'b0, i_led_index} < (lpf_pkg::LED_IDX_W + 1)'(NUM_LEDS);
        set_addr   = AW'(i_led_index);
        phase_inc  = {1'b0, r_phase} + 1'b1;
        phase_next = (phase_inc > {1'b0, i_pwm_top}) ? '0 : phase_inc[LW-1:0];
        cd_dec     = r_cd - 1'b1;

        // entries never written read as zero
        tgt_eff = r_tgt_v ? r_tgt_q : '0;
        cur_eff = r_cur_v ? r_cur_q : '0;
        if (tgt_eff > cur_eff) begin
            cur_step = cur_eff + 1'b1;
        end else if (tgt_eff < cur_eff) begin
            cur_step = cur_eff - 1'b1;
        end else begin
            cur_step = cur_eff;
        end

        // one write port on each memory: set words and sweep writeback never overlap
        tgt_we = i_cmd.set_wr && idx_ok;
        if (r_rd_pend) begin
            cur_we = r_step;
            cur_wa = r_rd_idx;
            cur_wd = cur_step;
        end else begin
            cur_we = i_cmd.set_wr && idx_ok && i_immediate;
            cur_wa = set_addr;
            cur_wd = lvl_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tgt_we) begin
            tgt_mem[set_addr] <= lvl_sat;
        end
        if (cur_we) begin
            cur_mem[cur_wa] <= cur_wd;
        end
        r_tgt_q <= tgt_mem[r_addr];
        r_cur_q <= cur_mem[r_addr];
        r_rd_idx <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt_vld <= '0;
            r_cur_vld <= '0;
            r_phase   <= lpf_pkg::PWM_TOP_RST;
            r_cd      <= lpf_pkg::FADE_INTV_RST;
            r_step    <= 1'b0;
            r_addr    <= '0;
            r_rd_pend <= 1'b0;
            r_tgt_v   <= 1'b0;
            r_cur_v   <= 1'b0;
        end else begin
            r_rd_pend <= i_cmd.sweep_rd;
            r_tgt_v   <= r_tgt_vld[r_addr];
            r_cur_v   <= r_cur_vld[r_addr];
            if (tgt_we) begin
                r_tgt_vld[set_addr] <= 1'b1;
            end
            if (cur_we) begin
                r_cur_vld[cur_wa] <= 1'b1;
            end
            if (i_cmd.tick_start) begin
                r_phase <= phase_next;
                r_step  <= (cd_dec == '0);
                r_cd    <= (cd_dec == '0) ? i_fade_intv : cd_dec;
                r_addr  <= '0;
            end else if (i_cmd.sweep_rd) begin
                r_addr <= r_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.tick_start) begin
            r_mask <= '0;
        end else if (r_rd_pend) begin
            r_mask[r_rd_idx] <= (r_phase < cur_eff);
        end
        if (i_cmd.mask_load) begin
            r_out_mask <= r_mask;
        end
    end

    assign o_sts.sweep_last = (r_addr == AW'(NUM_LEDS - 1));
    assign o_mask           = lpf_pkg::MASK_W'(r_out_mask);

endmodule
